// ----- design/insertion_sort_batch_assert.svh -----
// Assertion macros used by the insertion sorter port checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef INSERTION_SORT_BATCH_ASSERT_SVH
`define INSERTION_SORT_BATCH_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ISB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ISB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/isb_pkg.sv -----
// Package for the batch insertion sorter: store size and derived widths.
// No dependencies.
package isb_pkg;

  localparam int MaxLen = 16;
  localparam int DataW  = 32;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int CntW   = $clog2(MaxLen + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic signed [DataW-1:0] data_t;

endpackage

// ----- design/insertion_sort_batch.sv -----
// Batch insertion sorter: one compare/move unit shifts the sorted store one entry per step.
// Insert: each step reads the entry below the gap and moves it up if larger or equal;
// a smaller entry or the bottom stops the shift (at most MaxLen - 1 moves); an empty store
// takes the word at once. Emission reads each word and holds it until it is taken; one
// store read port serves both. Not ready for a new word until the insertion (and emission,
// on batch end) has finished. Reset clears count, overflow flag and control, not the store.
module insertion_sort_batch (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  isb_pkg::data_t      value_i,
  input  logic                batch_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output isb_pkg::data_t      sorted_value_o,
  output logic                run_end_o,
  output logic                dropped_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCompare,
    StPlace,
    StEmitRead,
    StEmitLoad,
    StEmitWait
  } state_e;

  state_e          state_q;
  isb_pkg::data_t  value_q;
  logic            last_q;
  isb_pkg::addr_t  pos_q;
  isb_pkg::addr_t  idx_q;
  isb_pkg::cnt_t   fill_q;
  logic            overflow_q;
  logic            out_valid_q;
  isb_pkg::data_t  out_data_q;
  logic            run_end_q;
  logic            dropped_q;

  isb_pkg::data_t  store_mem [isb_pkg::MaxLen];
  isb_pkg::data_t  rdata_q;
  isb_pkg::addr_t  raddr;
  isb_pkg::addr_t  waddr;
  isb_pkg::data_t  wdata;
  logic            we;
  logic            shift_up;
  logic            in_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign shift_up = rdata_q >= value_q;

  always_comb begin
    raddr = pos_q - isb_pkg::addr_t'(1);
    we    = 1'b0;
    waddr = pos_q;
    wdata = value_q;
    unique case (state_q)
      StEmitRead: raddr = idx_q;
      StCompare: begin
        if (shift_up) begin
          we    = 1'b1;
          wdata = rdata_q;
        end
      end
      StPlace: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    rdata_q <= store_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
      run_end_q   <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            value_q <= value_i;
            last_q  <= batch_end_i;
            pos_q   <= fill_q[isb_pkg::AddrW-1:0];
            idx_q   <= '0;
            if (fill_q == isb_pkg::cnt_t'(isb_pkg::MaxLen)) begin
              // Store full: the word is dropped, but a batch end still emits.
              overflow_q <= 1'b1;
              if (batch_end_i) begin
                state_q <= StEmitRead;
              end
            end else if (fill_q == '0) begin
              state_q <= StPlace;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead: state_q <= StCompare;
        StCompare: begin
          if (shift_up) begin
            pos_q <= pos_q - isb_pkg::addr_t'(1);
            state_q <= (pos_q == isb_pkg::addr_t'(1)) ? StPlace : StRead;
          end else begin
            state_q <= StPlace;
          end
        end
        StPlace: begin
          fill_q  <= fill_q + isb_pkg::cnt_t'(1);
          state_q <= last_q ? StEmitRead : StIdle;
        end
        StEmitRead: state_q <= StEmitLoad;
        StEmitLoad: begin
          out_valid_q <= 1'b1;
          out_data_q  <= rdata_q;
          run_end_q   <= isb_pkg::cnt_t'(idx_q) == (fill_q - isb_pkg::cnt_t'(1));
          dropped_q   <= overflow_q;
          state_q     <= StEmitWait;
        end
        StEmitWait: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (run_end_q) begin
              fill_q     <= '0;
              overflow_q <= 1'b0;
              state_q    <= StIdle;
            end else begin
              idx_q   <= idx_q + isb_pkg::addr_t'(1);
              state_q <= StEmitRead;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o     = state_q == StIdle;
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_data_q;
  assign run_end_o      = run_end_q;
  assign dropped_o      = dropped_q;

endmodule

// ----- design/isb_checker.sv -----
// Port-level checker for the batch insertion sorter, bound to its top level.
// Depends on isb_pkg and insertion_sort_batch_assert.svh.
`include "insertion_sort_batch_assert.svh"

module isb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           batch_end_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input isb_pkg::data_t sorted_value_o,
  input logic           run_end_o,
  input logic           dropped_o
);

  `ISB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out word dropped")
  `ISB_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(sorted_value_o) && $stable(run_end_o) && $stable(dropped_o), "out word changed")
  // The sorter works on one word at a time, so it never takes input while emitting.
  `ISB_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "input taken while emitting")
  `ISB_ASSERT_NEXT(a_no_emit_mid_batch, in_valid_i && in_ready_o && !batch_end_i,
    !out_valid_o, "result without batch end")
  `ISB_ASSERT_NEXT(a_run_end_stops, out_valid_o && out_ready_i && run_end_o,
    !out_valid_o, "result after run end")

endmodule

bind insertion_sort_batch isb_checker u_isb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .batch_end_i    (batch_end_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sorted_value_o (sorted_value_o),
  .run_end_o      (run_end_o),
  .dropped_o      (dropped_o)
);

// ----- tb/isb_order_checker.sv -----
`timescale 1ns / 1ps
// Order checker for the batch insertion sorter. It watches both word channels,
// keeps its own sorted store and compares every emitted word. Depends on isb_pkg.
module isb_order_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  isb_pkg::data_t value_i,
  input  logic           batch_end_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  isb_pkg::data_t sorted_value_i,
  input  logic           run_end_i,
  input  logic           dropped_i,
  output int             mismatch_count_o,
  output int             pending_o
);

  typedef struct packed {
    isb_pkg::data_t sorted_value;
    logic           run_end;
    logic           dropped;
  } sorted_word_t;

  sorted_word_t   expected_words[$];
  isb_pkg::data_t sorted_copy[isb_pkg::MaxLen];
  int             fill_copy;
  bit             overflow_copy;

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_word_t head;
    int pos;
    int k;
    if (!rst_ni) begin
      fill_copy = 0;
      overflow_copy = 1'b0;
      expected_words.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      // Emitted words are checked first: a word leaving in this cycle can only
      // belong to a batch that closed earlier.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("sorted_value: no word expected, got %0d", sorted_value_i);
          mismatch_count_o++;
        end else begin
          head = expected_words.pop_front();
          if (sorted_value_i !== head.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", head.sorted_value, sorted_value_i);
            mismatch_count_o++;
          end
          if (run_end_i !== head.run_end) begin
            $error("run_end: expected %0b, got %0b", head.run_end, run_end_i);
            mismatch_count_o++;
          end
          if (dropped_i !== head.dropped) begin
            $error("dropped: expected %0b, got %0b", head.dropped, dropped_i);
            mismatch_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (fill_copy < isb_pkg::MaxLen) begin
          // Larger or equal entries move up, so the new word lands below its equals.
          pos = fill_copy;
          while (pos > 0 && sorted_copy[pos-1] >= value_i) begin
            sorted_copy[pos] = sorted_copy[pos-1];
            pos--;
          end
          sorted_copy[pos] = value_i;
          fill_copy++;
        end else begin
          overflow_copy = 1'b1;
        end

        if (batch_end_i) begin
          for (k = 0; k < fill_copy; k++) begin
            head.sorted_value = sorted_copy[k];
            head.run_end = (k == fill_copy - 1);
            head.dropped = overflow_copy;
            expected_words.push_back(head);
          end
          fill_copy = 0;
          overflow_copy = 1'b0;
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the insertion sorter testbench: clock, reset, batches of words and
// random consumer stalls. Depends on isb_pkg, the sorter and isb_order_checker.
module tb;

  localparam int RandomWords = 250;
  localparam int CalmWords   = 210;
  localparam int SqueezeLen  = 600;
  localparam int DrainCycles = 120;
  localparam int CycleLimit  = 1000000;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  isb_pkg::data_t value_i     = '0;
  logic           batch_end_i = 1'b0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  isb_pkg::data_t sorted_value_o;
  logic           run_end_o;
  logic           dropped_o;

  int mismatch_count;
  int pending_words;

  bit calm          = 1'b0;
  bit squeeze_armed = 1'b0;
  bit squeeze_done  = 1'b0;
  int squeeze_left  = 0;
  int ready_run     = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  insertion_sort_batch uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .batch_end_i   (batch_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .run_end_o     (run_end_o),
    .dropped_o     (dropped_o)
  );

  isb_order_checker order_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .value_i         (value_i),
    .batch_end_i     (batch_end_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sorted_value_i  (sorted_value_o),
    .run_end_i       (run_end_o),
    .dropped_i       (dropped_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_words)
  );

  // Consumer side. The long hold-off stalls the sorter's emission and so blocks its input.
  always @(negedge clk_i) begin
    if (squeeze_armed && !squeeze_done) begin
      squeeze_left = SqueezeLen;
      squeeze_done = 1'b1;
    end
    if (squeeze_left > 0) begin
      out_ready_i <= 1'b0;
      squeeze_left--;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      ready_run = $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
      ready_run = $urandom_range(0, 29);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic offer_word(input isb_pkg::data_t word, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= word;
    batch_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int i;
    int len;
    int pick;
    int random_sent;
    isb_pkg::data_t word;
    random_sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A batch of one word.
    offer_word({1'b0, {31{1'b1}}}, 1'b1);

    // Both extremes, a duplicate, minus one and zero.
    offer_word(5, 1'b0);
    offer_word({1'b1, 31'h0}, 1'b0);
    offer_word(5, 1'b0);
    offer_word({1'b0, {31{1'b1}}}, 1'b0);
    offer_word(-1, 1'b0);
    offer_word(0, 1'b1);

    // Descending words shift the whole store each time; the closing word finds
    // the store full and must be dropped.
    for (i = 0; i < isb_pkg::MaxLen; i++) begin
      offer_word(isb_pkg::data_t'(isb_pkg::MaxLen - i), 1'b0);
    end
    offer_word({1'b1, 31'h0}, 1'b1);

    squeeze_armed = 1'b1;
    while (random_sent < RandomWords) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(isb_pkg::MaxLen + 1, isb_pkg::MaxLen + 4);
      else if (pick == 1) len = isb_pkg::MaxLen;
      else len = $urandom_range(1, isb_pkg::MaxLen);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       word = {1'b1, 31'h0};
          1:       word = {1'b0, {31{1'b1}}};
          2, 3:    word = isb_pkg::data_t'($urandom_range(0, 8)) - 4;
          default: word = $urandom;
        endcase
        offer_word(word, i == len - 1);
        random_sent++;
        if (random_sent >= CalmWords) calm = 1'b1;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
